/* rtl/core/cdq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cdq_pkg - shared definitions for the circular deque
// Opcode and status codes, default sizes and the cell control bundle.
// ---------------------------------------------------------------------------
package cdq_pkg;

  // default sizes
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OPCODE_W = 2;
  localparam int STATUS_W = 2;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_PUSH_REAR  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_POP_REAR   = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // broadcast control to every cell of the row
  typedef struct packed {
    logic                en;  // operation accepted and allowed
    logic [OPCODE_W-1:0] op;
  } cell_ctl_t;

endpackage
`default_nettype wire

/* rtl/core/cdq_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cdq_cell - one slot of the deque row
// Holds one entry and its valid bit; shifts toward the rear on a front push,
// toward the front on a front pop, and fills or drops at the rear boundary.
// ---------------------------------------------------------------------------
module cdq_cell #(
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cdq_pkg::cell_ctl_t    ctl,
  input  wire logic [DATA_WIDTH-1:0] push_data,
  input  wire logic [DATA_WIDTH-1:0] prev_data,   // neighbor toward the front
  input  wire logic                  prev_valid,
  input  wire logic [DATA_WIDTH-1:0] next_data,   // neighbor toward the rear
  input  wire logic                  next_valid,
  output logic [DATA_WIDTH-1:0]      data,
  output logic                       valid,
  output logic [DATA_WIDTH-1:0]      rear_tap     // entry if this is the rear
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  valid_r;
  logic                  valid_nxt;

  // next state of the slot
  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (ctl.en) begin
      unique case (ctl.op)
        cdq_pkg::OP_PUSH_REAR: begin
          // first empty slot takes the beat
          if (!valid_r && prev_valid) begin
            data_nxt  = push_data;
            valid_nxt = 1'b1;
          end
        end
        cdq_pkg::OP_PUSH_FRONT: begin
          data_nxt  = prev_data;
          valid_nxt = prev_valid;
        end
        cdq_pkg::OP_POP_REAR: begin
          if (valid_r && !next_valid) begin
            valid_nxt = 1'b0;
          end
        end
        cdq_pkg::OP_POP_FRONT: begin
          data_nxt  = next_data;
          valid_nxt = next_valid;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data     = data_r;
  assign valid    = valid_r;
  assign rear_tap = (valid_r && !next_valid) ? data_r : '0;

endmodule
`default_nettype wire

/* rtl/core/circular_deque_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// An accepted input beat gives its result beat in the cycle after it is taken.
// Throughput: one item per cycle while the result side is not stalled; the cell
// row shifts or fills as the beat is accepted and the rear entry is picked by an OR tree over the cell row.
// An output register holds the result, so input is taken while it waits
// as long as the result is taken in the same cycle.
// Reset clears the valid bits of all cells, the count and the output valid.
// ---------------------------------------------------------------------------
// circular_deque_unit - fixed-depth double-ended queue
// A row of cells kept packed from the front; each beat pushes or pops at
// either end and returns status, popped value and occupancy.
// ---------------------------------------------------------------------------
module circular_deque_unit #(
  parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF,
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [cdq_pkg::OPCODE_W-1:0]  in_opcode,
  input  wire logic signed [DATA_WIDTH-1:0]  in_push_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [cdq_pkg::STATUS_W-1:0]       out_status,
  output logic signed [DATA_WIDTH-1:0]       out_pop_value,
  output logic [CNT_W-1:0]                   out_occupancy
);

  logic                  accept;
  logic                  is_push;
  logic                  full;
  logic                  empty;
  logic [cdq_pkg::STATUS_W-1:0] status;
  cdq_pkg::cell_ctl_t    ctl;

  logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
  logic                  cell_valid [DEPTH];
  logic [DATA_WIDTH-1:0] cell_tap   [DEPTH];
  logic [DATA_WIDTH-1:0] rear_value;
  logic [DATA_WIDTH-1:0] pop_value;

  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cnt_nxt;

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [cdq_pkg::STATUS_W-1:0] out_status_r;
  logic [DATA_WIDTH-1:0] out_pop_value_r;
  logic [CNT_W-1:0]      out_occupancy_r;

  // handshake
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // status decision
  assign is_push = !in_opcode[1];
  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);

  always_comb begin
    if (is_push) begin
      status = full ? cdq_pkg::ST_FULL : cdq_pkg::ST_OK;
    end else begin
      status = empty ? cdq_pkg::ST_EMPTY : cdq_pkg::ST_OK;
    end
  end

  assign ctl = '{en: accept && (status == cdq_pkg::ST_OK), op: in_opcode};

  // cell row, index 0 is the front
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_d;
    logic                  prev_v;
    logic [DATA_WIDTH-1:0] next_d;
    logic                  next_v;

    if (i == 0) begin : g_head
      assign prev_d = in_push_value;
      assign prev_v = 1'b1;
    end else begin : g_mid_p
      assign prev_d = cell_data[i-1];
      assign prev_v = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_d = '0;
      assign next_v = 1'b0;
    end else begin : g_mid_n
      assign next_d = cell_data[i+1];
      assign next_v = cell_valid[i+1];
    end

    cdq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .push_data (in_push_value),
      .prev_data (prev_d),
      .prev_valid(prev_v),
      .next_data (next_d),
      .next_valid(next_v),
      .data      (cell_data[i]),
      .valid     (cell_valid[i]),
      .rear_tap  (cell_tap[i])
    );
  end

  // only the rear cell drives a nonzero tap
  always_comb begin
    rear_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_value = rear_value | cell_tap[i];
    end
  end

  // popped value and next count
  always_comb begin
    pop_value = '0;
    cnt_nxt   = cnt_r;
    if (ctl.en) begin
      unique case (in_opcode) inside
        cdq_pkg::OP_PUSH_REAR,
        cdq_pkg::OP_PUSH_FRONT: cnt_nxt = cnt_r + CNT_W'(1);
        cdq_pkg::OP_POP_REAR: begin
          pop_value = rear_value;
          cnt_nxt   = cnt_r - CNT_W'(1);
        end
        cdq_pkg::OP_POP_FRONT: begin
          pop_value = cell_data[0];
          cnt_nxt   = cnt_r - CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r    <= status;
      out_pop_value_r <= pop_value;
      out_occupancy_r <= cnt_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_pop_value = out_pop_value_r;
  assign out_occupancy = out_occupancy_r;

endmodule
`default_nettype wire

/* rtl/core/cdq_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cdq_port_checker - port-level checks for the circular deque
// Watches result beats for consistent status, value and occupancy.
// ---------------------------------------------------------------------------
module cdq_port_checker #(
  parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF,
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [cdq_pkg::STATUS_W-1:0] out_status,
  input wire logic [DATA_WIDTH-1:0]        out_pop_value,
  input wire logic [CNT_W-1:0]             out_occupancy
);

  // occupancy stays within depth
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_occupancy <= CNT_W'(DEPTH)))
    else $error("occupancy beyond depth");

  // refused push only when full, with no value
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == cdq_pkg::ST_FULL) |->
      (out_occupancy == CNT_W'(DEPTH) && out_pop_value == '0))
    else $error("full status inconsistent");

  // refused pop only when empty, with no value
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == cdq_pkg::ST_EMPTY) |->
      (out_occupancy == '0 && out_pop_value == '0))
    else $error("empty status inconsistent");

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_status) && $stable(out_pop_value)
       && $stable(out_occupancy)))
    else $error("stalled result changed");

endmodule

bind circular_deque_unit cdq_port_checker #(
  .DEPTH     (DEPTH),
  .DATA_WIDTH(DATA_WIDTH)
) u_cdq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_status   (out_status),
  .out_pop_value(out_pop_value),
  .out_occupancy(out_occupancy)
);
`default_nettype wire

/* test/cdq_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cdq_checker - result checker for the circular deque
// Watches the input and result channels, keeps its own deque model, and
// compares every result beat field by field with the oldest predicted reply.
// ---------------------------------------------------------------------------
module cdq_checker
  import cdq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [OPCODE_W-1:0]          in_opcode,
  input  logic signed [DATA_WIDTH-1:0] in_push_value,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [STATUS_W-1:0]          out_status,
  input  logic signed [DATA_WIDTH-1:0] out_pop_value,
  input  logic [CNT_W-1:0]             out_occupancy,
  output int                           mismatch_count,
  output int                           replies_pending
);

  typedef struct packed {
    logic [STATUS_W-1:0]          status;
    logic signed [DATA_WIDTH-1:0] pop_value;
    logic [CNT_W-1:0]             occupancy;
  } deque_reply_t;

  // model of the ring store and its pointers
  logic signed [DATA_WIDTH-1:0] slots [DEPTH];
  int unsigned head_idx;
  int unsigned tail_idx;
  int unsigned fill;

  deque_reply_t reply_q [$];

  // apply one operation to the model and return the reply it produces
  function automatic deque_reply_t deque_apply(input logic [OPCODE_W-1:0] op,
                                               input logic signed [DATA_WIDTH-1:0] val);
    deque_reply_t r;
    r.status    = ST_OK;
    r.pop_value = '0;
    case (op)
      OP_PUSH_REAR, OP_PUSH_FRONT: begin
        if (fill == DEPTH) begin
          r.status = ST_FULL;
        end else if (op == OP_PUSH_REAR) begin
          tail_idx = (tail_idx + 1) % DEPTH;
          slots[tail_idx] = val;
          fill++;
        end else begin
          head_idx = (head_idx + DEPTH - 1) % DEPTH;
          slots[head_idx] = val;
          fill++;
        end
      end
      default: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else if (op == OP_POP_REAR) begin
          r.pop_value = slots[tail_idx];
          tail_idx = (tail_idx + DEPTH - 1) % DEPTH;
          fill--;
        end else begin
          r.pop_value = slots[head_idx];
          head_idx = (head_idx + 1) % DEPTH;
          fill--;
        end
      end
    endcase
    r.occupancy = CNT_W'(fill);
    return r;
  endfunction

  initial begin
    mismatch_count  = 0;
    replies_pending = 0;
  end

  // result beats retire before the input beat of the same edge is predicted
  always @(posedge clk) begin
    deque_reply_t want;
    if (!rst_n) begin
      head_idx = 0;
      tail_idx = DEPTH - 1;
      fill     = 0;
      reply_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: status %0d pop %0d occ %0d",
                   $realtime, out_status, out_pop_value, out_occupancy);
          mismatch_count++;
        end else begin
          want = reply_q.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $realtime, want.status, out_status);
            mismatch_count++;
          end
          if (out_pop_value !== want.pop_value) begin
            $display("%0t: pop_value expected %0d got %0d",
                     $realtime, want.pop_value, out_pop_value);
            mismatch_count++;
          end
          if (out_occupancy !== want.occupancy) begin
            $display("%0t: occupancy expected %0d got %0d",
                     $realtime, want.occupancy, out_occupancy);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready)
        reply_q.push_back(deque_apply(in_opcode, in_push_value));
    end
    replies_pending = reply_q.size();
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb - testbench top for circular_deque_unit
// Drives directed and random deque operations with random idling on both
// channels and one long result stall; the checker module judges results.
// ---------------------------------------------------------------------------
module tb;
  import cdq_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int DATA_WIDTH  = DATA_WIDTH_DEF;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int RANDOM_OPS  = 830;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 40;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [OPCODE_W-1:0]          in_opcode;
  logic signed [DATA_WIDTH-1:0] in_push_value;
  logic                         out_valid;
  logic                         out_ready;
  logic [STATUS_W-1:0]          out_status;
  logic signed [DATA_WIDTH-1:0] out_pop_value;
  logic [CNT_W-1:0]             out_occupancy;

  int mismatch_total;
  int replies_outstanding;
  int quiet_cycles;
  int hold_left;
  bit gaps_on;
  bit hold_request;

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  circular_deque_unit #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_pop_value (out_pop_value),
    .out_occupancy (out_occupancy)
  );

  cdq_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W)
  ) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_pop_value   (out_pop_value),
    .out_occupancy   (out_occupancy),
    .mismatch_count  (mismatch_total),
    .replies_pending (replies_outstanding)
  );

  // offer one beat, entered and left at a falling edge
  task automatic send_op(input logic [OPCODE_W-1:0] op,
                         input logic signed [DATA_WIDTH-1:0] val);
    while (gaps_on && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_push_value <= val;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // push values lean toward the sign and all-ones extremes now and then
  function automatic logic signed [DATA_WIDTH-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(DATA_WIDTH-1){1'b0}}};
      1:       return {1'b0, {(DATA_WIDTH-1){1'b1}}};
      2:       return '1;
      3:       return '0;
      default: return DATA_WIDTH'($urandom);
    endcase
  endfunction

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(gaps_on && $urandom_range(0, 99) < 19);
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // stimulus and verdict
  initial begin
    int push_pct;
    logic [OPCODE_W-1:0] op;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = OP_PUSH_REAR;
    in_push_value = '0;
    gaps_on       = 1'b1;
    hold_request  = 1'b0;
    quiet_cycles  = 0;
    push_pct      = 50;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // pops on empty, then a front push into the empty deque and a rear pop of it
    send_op(OP_POP_REAR, '1);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_PUSH_FRONT, {1'b0, {(DATA_WIDTH-1){1'b1}}});
    send_op(OP_POP_REAR, '0);
    // fill to the brim from both ends, mostly with extreme values
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0:       send_op(OP_PUSH_REAR, {1'b1, {(DATA_WIDTH-1){1'b0}}});
        1:       send_op(OP_PUSH_FRONT, '1);
        2:       send_op(OP_PUSH_REAR, '0);
        default: send_op(OP_PUSH_FRONT, DATA_WIDTH'($urandom));
      endcase
    end
    // refused pushes on a full deque, then pops from both ends
    send_op(OP_PUSH_REAR, '1);
    send_op(OP_PUSH_FRONT, '0);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_REAR, '1);

    // random phases that swing between draining and filling
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 15;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      gaps_on = !(n >= 500 && n < 650);
      if (n == 300)
        hold_request = 1'b1;
      if ($urandom_range(0, 99) < push_pct)
        op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
      else
        op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
      send_op(op, pick_value());
    end
    in_valid <= 1'b0;

    // drain, then keep the clock running for any stray result
    while (replies_outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_total == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* files.f */
rtl/core/cdq_pkg.sv
rtl/core/cdq_cell.sv
rtl/core/circular_deque_unit.sv
rtl/core/cdq_checker.sv
test/cdq_checker.sv
test/tb.sv
